// ===== hdl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants for the checksummed frame receiver: frame size default,
// preamble and header byte values, header length.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  // default number of bytes held for one frame
  localparam int unsigned FRAME_BYTES = 32;

  // frame layout
  localparam logic [7:0]  PREAMBLE = 8'hFC;
  localparam logic [7:0]  HDR_A    = 8'h01;
  localparam logic [7:0]  HDR_B    = 8'h30;
  localparam int unsigned HDR_LEN  = 5;

endpackage : cfr_pkg

`default_nettype wire

// ===== hdl/checksummed_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_unit
// Hunts for frames (preamble, type, two header bytes, length, payload,
// checksum) in a byte stream; for a frame whose additive checksum matches
// it emits one result per payload byte, or one without data if empty.
// ----------------------------------------------------------------------------
// sequence: a received byte is transferred, then makes one pass through
//   the shared adder/compare step; the checksum byte of a good frame then
//   emits its results, each as a ram read (none if empty), then present
// input: a new byte is taken only once the last one and any results it
//   emits are done; the read step comes from the store's registered read port
// reset: clears the sequencer, byte position and running sum; the frame
//   store is not cleared
`default_nettype none

module checksummed_frame_receiver_unit #(
  parameter int unsigned FrameBytes = cfr_pkg::FRAME_BYTES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic       action_i,
  input  wire logic [7:0] rx_byte_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic [7:0] frame_type_o,
  output      logic [4:0] payload_length_o,
  output      logic [4:0] byte_index_o,
  output      logic [7:0] data_byte_o,
  output      logic       has_data_o,
  output      logic       last_o
);

  localparam int unsigned AW = $clog2(FrameBytes);
  localparam int unsigned PW = $clog2(FrameBytes + 1);
  localparam int unsigned LW = (FrameBytes - cfr_pkg::HDR_LEN > 1) ?
                               $clog2(FrameBytes - cfr_pkg::HDR_LEN) : 1;
  localparam logic [7:0]  LenLimit = 8'(FrameBytes - cfr_pkg::HDR_LEN);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_PROC    = 4'b0010,
    ST_EMIT_RD = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_e;

  state_e         state_q, state_d;
  logic           action_q;
  logic [7:0]     byte_q;
  logic [PW-1:0]  pos_q, pos_d;
  logic [7:0]     sum_q, sum_d;
  logic [7:0]     type_q, type_d;
  logic [LW-1:0]  len_q, len_d;
  logic [LW-1:0]  idx_q, idx_d;
  logic           has_data_q, has_data_d;

  logic           in_xfer, out_xfer;
  logic [7:0]     add_res;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;
  logic [31:0]    len_ext, idx_ext;
  logic           idx_last;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // shared adder: accumulates the sum and checks the checksum byte
  // (0xFC - sum == b is the same as sum + b == 0xFC)
  assign add_res = sum_q + byte_q;

  assign idx_last  = (idx_q == len_q - LW'(1));
  assign ram_we    = (state_q == ST_PROC) && !action_q && (pos_q < PW'(FrameBytes));
  assign ram_re    = (state_q == ST_EMIT_RD);
  assign ram_raddr = AW'(cfr_pkg::HDR_LEN) + AW'(idx_q);

  cfr_ram #(
    .Width(8),
    .Depth(FrameBytes)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q[AW-1:0]),
    .wdata_i(byte_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    type_d     = type_q;
    len_d      = len_q;
    idx_d      = idx_q;
    has_data_d = has_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_PROC;
        end
      end
      ST_PROC: begin
        state_d = ST_IDLE;
        pos_d   = pos_q + PW'(1);
        sum_d   = add_res;
        if (action_q) begin
          pos_d = '0;
          sum_d = '0;
        end else if (pos_q == PW'(0)) begin
          if (byte_q != cfr_pkg::PREAMBLE) begin
            pos_d = '0;
            sum_d = '0;
          end
        end else if (pos_q == PW'(1)) begin
          type_d = byte_q;
        end else if (pos_q == PW'(2)) begin
          if (byte_q != cfr_pkg::HDR_A) begin
            pos_d = '0;
            sum_d = '0;
          end
        end else if (pos_q == PW'(3)) begin
          if (byte_q != cfr_pkg::HDR_B) begin
            pos_d = '0;
            sum_d = '0;
          end
        end else if (pos_q == PW'(4)) begin
          len_d = byte_q[LW-1:0];
          if (byte_q >= LenLimit) begin
            pos_d = '0;
            sum_d = '0;
          end
        end else if (pos_q >= PW'(cfr_pkg::HDR_LEN) + PW'(len_q)) begin
          // checksum byte ends the frame either way
          pos_d = '0;
          sum_d = '0;
          idx_d = '0;
          if (add_res == cfr_pkg::PREAMBLE) begin
            has_data_d = (len_q != '0);
            state_d    = (len_q != '0) ? ST_EMIT_RD : ST_EMIT;
          end
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer) begin
          if (!has_data_q || idx_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + LW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q <= action_i;
      byte_q   <= rx_byte_i;
    end
    type_q     <= type_d;
    len_q      <= len_d;
    idx_q      <= idx_d;
    has_data_q <= has_data_d;
  end

  assign len_ext = 32'(len_q);
  assign idx_ext = 32'(idx_q);

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = (state_q == ST_EMIT);
  assign frame_type_o     = type_q;
  assign payload_length_o = has_data_q ? len_ext[4:0] : 5'd0;
  assign byte_index_o     = has_data_q ? idx_ext[4:0] : 5'd0;
  assign data_byte_o      = has_data_q ? ram_rdata : 8'd0;
  assign has_data_o       = has_data_q;
  assign last_o           = !has_data_q || idx_last;

  // a result never overlaps taking a new byte
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result offered while input is open");

  // every transfer in goes through the processing step next
  a_in_to_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_PROC))
    else $error("accepted byte not processed");

  // payload index stays inside the frame's length
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_data_q) |-> (idx_q < len_q))
    else $error("payload index beyond length");

  // an empty-payload result is always the final one
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_data_o) |-> last_o)
    else $error("empty-payload result not marked last");

  // byte position never runs past the frame store
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PW'(FrameBytes))
    else $error("byte position overflow");

endmodule : checksummed_frame_receiver_unit

`default_nettype wire

// ===== hdl/cfr_ram.sv =====
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = cfr_pkg::FRAME_BYTES
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : cfr_ram

`default_nettype wire
